// File: sv/msd_pkg.sv
`default_nettype none

package msd_pkg;

    // default size limit for a whole packet, marker and header included
    localparam int unsigned MAX_PACKET_BYTES_DEF = 1024;

    // marker bytes, first received in the top byte
    localparam logic [31:0] SYNC_WORD = 32'h4C43_5431;

    // marker plus header bytes counted into the packet size
    localparam logic [17:0] FULL_HEADER_BYTES = 18'd17;

    // phase codes
    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_PADDING = 2'd3;

    // header byte positions
    localparam logic [3:0] HDR_TYPE        = 4'd0;
    localparam logic [3:0] HDR_SESSION_END = 4'd8;
    localparam logic [3:0] HDR_PAY_LO      = 4'd9;
    localparam logic [3:0] HDR_PAY_HI      = 4'd10;
    localparam logic [3:0] HDR_PAD_LO      = 4'd11;

    // result kinds
    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // reject reasons
    localparam logic [1:0] REASON_NONE     = 2'd0;
    localparam logic [1:0] REASON_EMPTY    = 2'd1;
    localparam logic [1:0] REASON_TOO_BIG  = 2'd2;
    localparam logic [1:0] REASON_BAD_TYPE = 2'd3;

    // known packet types
    localparam logic [7:0] TYPE_ONE = 8'd1;
    localparam logic [7:0] TYPE_TWO = 8'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  reason;
        logic [7:0]  ptype;
        logic [63:0] session;
        logic [15:0] pay_len;
        logic [15:0] pad_len;
        logic [7:0]  pbyte;
        logic        last;
    } msd_result_t;

endpackage

`default_nettype wire

// File: sv/msd_parser.sv
`default_nettype none

module msd_parser #(
    parameter int unsigned MAX_PACKET_BYTES = msd_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          rx_byte,
    output logic                     push,
    output msd_pkg::msd_result_t     result
);

    import msd_pkg::*;

    logic [31:0] window_reg,    window_next;
    logic [1:0]  phase_reg,     phase_next;
    logic [3:0]  hdr_count_reg, hdr_count_next;
    logic [7:0]  type_reg,      type_next;
    logic [63:0] session_reg,   session_next;
    logic [15:0] pay_len_reg,   pay_len_next;
    logic [15:0] pad_len_reg,   pad_len_next;
    logic [15:0] remain_reg,    remain_next;

    logic [31:0] window_shift;
    logic [2:0]  session_idx;
    logic [15:0] pad_new;
    logic [17:0] total;
    logic [15:0] remain_dec;
    logic [1:0]  kind;
    logic [1:0]  reason;
    logic        last;
    logic [7:0]  pbyte;

    always_comb
    begin
        window_next    = window_reg;
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        type_next      = type_reg;
        session_next   = session_reg;
        pay_len_next   = pay_len_reg;
        pad_len_next   = pad_len_reg;
        remain_next    = remain_reg;
        push           = 1'b0;
        kind           = KIND_ACCEPT;
        reason         = REASON_NONE;
        last           = 1'b0;
        pbyte          = 8'd0;

        window_shift = {window_reg[23:0], rx_byte};
        session_idx  = 3'(hdr_count_reg - 4'd1);
        pad_new      = {rx_byte, pad_len_reg[7:0]};
        total        = FULL_HEADER_BYTES + {2'b00, pay_len_reg} + {2'b00, pad_new};
        remain_dec   = remain_reg - 16'd1;

        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (window_shift == SYNC_WORD)
                    begin
                        window_next    = 32'd0;
                        phase_next     = PH_HEADER;
                        hdr_count_next = 4'd0;
                    end
                    else
                    begin
                        window_next = window_shift;
                    end
                end
                PH_HEADER:
                begin
                    hdr_count_next = hdr_count_reg + 4'd1;
                    if (hdr_count_reg == HDR_TYPE)
                    begin
                        type_next = rx_byte;
                    end
                    else if (hdr_count_reg <= HDR_SESSION_END)
                    begin
                        session_next[{session_idx, 3'b000} +: 8] = rx_byte;
                    end
                    else if (hdr_count_reg == HDR_PAY_LO)
                    begin
                        pay_len_next[7:0] = rx_byte;
                    end
                    else if (hdr_count_reg == HDR_PAY_HI)
                    begin
                        pay_len_next[15:8] = rx_byte;
                    end
                    else if (hdr_count_reg == HDR_PAD_LO)
                    begin
                        pad_len_next[7:0] = rx_byte;
                    end
                    else
                    begin
                        // final header byte: decide the packet
                        pad_len_next   = pad_new;
                        hdr_count_next = 4'd0;
                        push           = 1'b1;
                        if (pay_len_reg == 16'd0 && pad_new == 16'd0)
                            reason = REASON_EMPTY;
                        else if (total > 18'(MAX_PACKET_BYTES))
                            reason = REASON_TOO_BIG;
                        else if (type_reg != TYPE_ONE && type_reg != TYPE_TWO)
                            reason = REASON_BAD_TYPE;
                        if (reason != REASON_NONE)
                        begin
                            kind       = KIND_REJECT;
                            phase_next = PH_HUNT;
                        end
                        else if (pay_len_reg != 16'd0)
                        begin
                            phase_next  = PH_PAYLOAD;
                            remain_next = pay_len_reg;
                        end
                        else if (pad_new != 16'd0)
                        begin
                            phase_next  = PH_PADDING;
                            remain_next = pad_new;
                        end
                        else
                        begin
                            phase_next  = PH_HUNT;
                            remain_next = 16'd0;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (remain_reg == 16'd0)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        push        = 1'b1;
                        kind        = KIND_PAYLOAD;
                        pbyte       = rx_byte;
                        last        = (remain_reg == 16'd1);
                        remain_next = remain_dec;
                        if (remain_dec == 16'd0)
                        begin
                            if (pad_len_reg != 16'd0)
                            begin
                                phase_next  = PH_PADDING;
                                remain_next = pad_len_reg;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                    end
                end
                default:
                begin
                    // padding is dropped silently
                    if (remain_reg != 16'd0)
                        remain_next = remain_dec;
                    if (remain_reg <= 16'd1)
                        phase_next = PH_HUNT;
                end
            endcase
        end

        result.kind    = kind;
        result.reason  = reason;
        result.ptype   = type_next;
        result.session = session_next;
        result.pay_len = pay_len_next;
        result.pad_len = pad_len_next;
        result.pbyte   = pbyte;
        result.last    = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= 32'd0;
            phase_reg     <= PH_HUNT;
            hdr_count_reg <= 4'd0;
            type_reg      <= 8'd0;
            session_reg   <= 64'd0;
            pay_len_reg   <= 16'd0;
            pad_len_reg   <= 16'd0;
            remain_reg    <= 16'd0;
        end
        else
        begin
            window_reg    <= window_next;
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            type_reg      <= type_next;
            session_reg   <= session_next;
            pay_len_reg   <= pay_len_next;
            pad_len_reg   <= pad_len_next;
            remain_reg    <= remain_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/msd_out_buf.sv
`default_nettype none

module msd_out_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire msd_pkg::msd_result_t push_data,
    output logic                      can_push,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output msd_pkg::msd_result_t      out_data
);

    import msd_pkg::*;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    msd_result_t main_reg;
    msd_result_t skid_reg;
    logic        main_free;

    assign main_free = !main_valid_reg || out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // data path, no reset needed
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/marker_sync_packet_deframer.sv
// marker-synchronised packet deframer
// input channel: one received word (rx_byte) per in_valid/in_ready handshake
// output channel: one result word per out_valid/out_ready handshake, fields on
//   result_kind, reject_reason, packet_type, session_tag, payload_length,
//   padding_length, payload_byte and last_payload
// the block hunts for the four-word marker, captures the 13-word header and
//   gives one accept or reject result on the last header word; accepted
//   payload words come out one result each, padding words give no result
// result path: the result of a taken input word goes to the output register,
//   or to the skid register while the output register is held
// throughput: one input word per cycle while in_ready is high; the parser
//   state updates in the cycle of the handshake
// stall: a two-entry output buffer (output register plus skid register) sits
//   behind the parser; in_ready falls only when both entries hold results,
//   so input words keep flowing while one result waits to be taken
// reset: rst_n clears the parser to hunting with an empty marker window and
//   clears both output entries; in_ready is high straight after reset
`default_nettype none

module marker_sync_packet_deframer #(
    parameter int unsigned MAX_PACKET_BYTES = msd_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [1:0]       reject_reason,
    output logic [7:0]       packet_type,
    output logic [63:0]      session_tag,
    output logic [15:0]      payload_length,
    output logic [15:0]      padding_length,
    output logic [7:0]       payload_byte,
    output logic             last_payload
);

    import msd_pkg::*;

    logic        accept;
    logic        push;
    msd_result_t parse_result;
    msd_result_t out_data;

    // a word is taken whenever the buffer has a free entry
    assign accept = in_valid && in_ready;

    msd_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .push    (push),
        .result  (parse_result)
    );

    msd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (parse_result),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // unpack the result word onto the field ports
    assign result_kind    = out_data.kind;
    assign reject_reason  = out_data.reason;
    assign packet_type    = out_data.ptype;
    assign session_tag    = out_data.session;
    assign payload_length = out_data.pay_len;
    assign padding_length = out_data.pad_len;
    assign payload_byte   = out_data.pbyte;
    assign last_payload   = out_data.last;

    // a full buffer always has a result on show
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result on show");

    // a reject always carries a reason
    a_reject_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_REJECT) |-> reject_reason != REASON_NONE)
        else $error("reject without a reason");

    // an accepted header is of a known type and not empty
    a_accept_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_ACCEPT) |->
        (reject_reason == REASON_NONE &&
         (packet_type == TYPE_ONE || packet_type == TYPE_TWO) &&
         (payload_length != 16'd0 || padding_length != 16'd0)))
        else $error("accepted header fails its checks");

    // payload words only belong to packets with a payload
    a_payload_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_PAYLOAD) |->
        (payload_length != 16'd0 && reject_reason == REASON_NONE))
        else $error("payload word from a packet without payload");

    // only payload words carry the last flag
    a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != KIND_PAYLOAD) |-> (!last_payload && payload_byte == 8'd0))
        else $error("last flag or data on a header result");

endmodule

`default_nettype wire
